@@ rtl/pfx_pkg.sv @@
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared constants and controller/datapath interface types for the postfix
// expression evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int DATA_W = 32;
  localparam int CHAR_W = 8;
  localparam int FLAG_W = 3;

  // operator characters
  localparam logic [CHAR_W-1:0] CH_ADD = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_SUB = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_MUL = 8'h2A;  // '*'
  localparam logic [CHAR_W-1:0] CH_DIV = 8'h2F;  // '/'

  // operand bytes push (byte - '0')
  localparam logic [DATA_W-1:0] ASCII_ZERO = 32'd48;

  // controller -> datapath
  typedef struct packed {
    logic load;       // take the incoming item
    logic pop;        // pop one entry (read issued to the stack memory)
    logic cap_b;      // capture popped value into b
    logic cap_a;      // capture popped value into a
    logic alu;        // compute add/sub/mul or operand value into r
    logic div_start;  // launch the divider on a / b
    logic div_cap;    // capture quotient into r
    logic push;       // push r
    logic emit;       // load the output register, clear stack and flags
  } pfx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic is_div;
    logic last;
    logic div_done;
    logic out_free;
  } pfx_stat_t;

endpackage

@@ rtl/pfx_div.sv @@
// ----------------------------------------------------------------------------
// pfx_div
// Signed 32-bit divider, truncating toward zero. Restoring radix-2 on the
// magnitudes, one quotient bit per cycle; done pulses after 32 steps.
// ----------------------------------------------------------------------------
module pfx_div
  import pfx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int SW = $clog2(DATA_W + 1);

  logic              busy;
  logic [SW-1:0]     steps;
  logic              neg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem, quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(DATA_W);
      end else if (busy) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      rem <= '0;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/pfx_dpath.sv @@
// ----------------------------------------------------------------------------
// pfx_dpath
// Datapath: operand stack memory with entry count, operand registers, ALU,
// divider, sticky error flags and the result output register.
// ----------------------------------------------------------------------------
module pfx_dpath
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  input  pfx_cmd_t          cmd,
  output pfx_stat_t         st,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic [FLAG_W-1:0] m_tuser
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_dec;
  logic              full;
  logic              pop_empty;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] r;
  logic              flag_under;
  logic              flag_over;
  logic              flag_div0;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  assign cnt_dec = count - CW'(1);
  assign full    = (count == CW'(STACK_DEPTH));

  assign st.is_op    = (char_code == CH_ADD) || (char_code == CH_SUB) ||
                       (char_code == CH_MUL) || (char_code == CH_DIV);
  assign st.is_div   = (char_code == CH_DIV);
  assign st.last     = last;
  assign st.div_done = div_done;
  assign st.out_free = !m_tvalid || m_tready;

  pfx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (div_q)
  );

  // stack memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[count[AW-1:0]] <= r;
    end
    if (cmd.pop) begin
      rd_data <= mem[cnt_dec[AW-1:0]];
    end
  end

  // control state: count, flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      flag_under <= 1'b0;
      flag_over  <= 1'b0;
      flag_div0  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.pop) begin
        if (count == '0) begin
          flag_under <= 1'b1;
        end else begin
          count <= cnt_dec;
        end
      end
      if (cmd.push) begin
        if (full) begin
          flag_over <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.div_start && (b == '0)) begin
        flag_div0 <= 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid   <= 1'b1;
        count      <= '0;
        flag_under <= 1'b0;
        flag_over  <= 1'b0;
        flag_div0  <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_code <= in_char;
      last      <= in_last;
    end
    if (cmd.pop) begin
      pop_empty <= (count == '0);
    end
    if (cmd.cap_b) begin
      b <= pop_empty ? '0 : rd_data;
    end
    if (cmd.cap_a) begin
      a <= pop_empty ? '0 : rd_data;
    end
    if (cmd.alu) begin
      case (char_code)
        CH_ADD:  r <= a + b;
        CH_SUB:  r <= a - b;
        CH_MUL:  r <= a * b;
        default: r <= {{(DATA_W-CHAR_W){1'b0}}, char_code} - ASCII_ZERO;
      endcase
    end
    if (cmd.div_cap) begin
      r <= (b == '0) ? '0 : div_q;
    end
    if (cmd.emit) begin
      m_tdata <= b;
      m_tuser <= {flag_div0, flag_over, flag_under};
    end
  end

endmodule

@@ rtl/pfx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfx_ctrl
// Controller: sequences pops, the operation and the push for each item, and
// the final pop and result hand-off after an expression's last item.
// ----------------------------------------------------------------------------
module pfx_ctrl
  import pfx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  pfx_stat_t st,
  output pfx_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_B,
    S_POP_A,
    S_CAP_A,
    S_EXEC,
    S_DIV_WAIT,
    S_PUSH,
    S_FIN_POP,
    S_FIN_CAP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_POP_B;
        end
      end
      S_POP_B: begin
        if (st.is_op) begin
          cmd.pop    = 1'b1;
          state_next = S_POP_A;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_POP_A: begin
        cmd.cap_b  = 1'b1;
        cmd.pop    = 1'b1;
        state_next = S_CAP_A;
      end
      S_CAP_A: begin
        cmd.cap_a  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (st.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end else begin
          cmd.alu    = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          cmd.div_cap = 1'b1;
          state_next  = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = st.last ? S_FIN_POP : S_IDLE;
      end
      S_FIN_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        cmd.cap_b  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/postfix_expression_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix (RPN) expression evaluator over a bounded stack of signed 32-bit
// operands.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one expression byte per item in s_tdata, s_tlast set on
//   the final byte. '+', '-', '*', '/' pop b then a and push a op b; any other
//   byte pushes (byte - 48). Errors (underflow, overflow, divide by zero) are
//   sticky until the end of the expression.
//   Output stream m_*: one item per expression, m_tdata = final value,
//   m_tuser = {divide_by_zero, overflow, underflow}.
//   Sequence: an operand byte is loaded, converted and pushed; +, - and * pop
//   b then a, compute and push; / runs the one-bit-per-cycle divider (32 steps)
//   before the push. A last byte adds the final pop and result hand-off. Pops
//   and pushes go through the single-port stack memory, one access per cycle.
//   The output register lets the next expression start while a result waits;
//   a stalled receiver holds the block only when the next result is ready.
//   Reset clears the entry count, flags and output valid; stack contents are
//   not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_code
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] result_value
  output logic [FLAG_W-1:0] m_tuser    // [0] underflow, [1] overflow, [2] divide_by_zero
);

  pfx_cmd_t  cmd;
  pfx_stat_t st;

  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pfx_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_char  (s_tdata),
    .in_last  (s_tlast),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // one item in flight: input closes right after an accept
  a_single_item : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // the divider only finishes while the controller waits for it
  a_div_handoff : assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> cmd.div_cap)
    else $error("quotient ready outside the divide wait");

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result emitted over an unaccepted item");
`endif

endmodule

@@ test/pfx_result_checker.sv @@
// ----------------------------------------------------------------------------
// pfx_result_checker
// Watches both streams of the postfix evaluator. Every accepted input byte
// is evaluated on a private operand stack. An expression's last byte queues
// the expected final value and flags. Each output item is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module pfx_result_checker
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,
  input  logic              s_tlast,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DATA_W-1:0] m_tdata,
  input  logic [FLAG_W-1:0] m_tuser,
  output int                error_count,
  output int                pending_results,
  output int                results_checked,
  output int                underflow_seen,
  output int                overflow_seen,
  output int                div0_seen
);

  typedef struct packed {
    logic              div0;
    logic              over;
    logic              under;
    logic [DATA_W-1:0] value;
  } expr_result_t;

  logic [DATA_W-1:0] operand_stack [STACK_DEPTH];
  int                stack_fill;
  logic              under_flag;
  logic              over_flag;
  logic              div0_flag;
  expr_result_t      expected_results [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [DATA_W-1:0] pop_operand();
    if (stack_fill == 0) begin
      under_flag = 1'b1;
      return '0;
    end
    stack_fill--;
    return operand_stack[stack_fill];
  endfunction

  function automatic void push_operand(input logic [DATA_W-1:0] v);
    if (stack_fill >= STACK_DEPTH) begin
      over_flag = 1'b1;
    end else begin
      operand_stack[stack_fill] = v;
      stack_fill++;
    end
  endfunction

  // signed divide, truncating toward zero; min / -1 wraps back to min
  function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] a,
                                                             input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] q;
    if (b == '0) begin
      div0_flag = 1'b1;
      return '0;
    end
    mag_a = a[DATA_W-1] ? -a : a;
    mag_b = b[DATA_W-1] ? -b : b;
    q = mag_a / mag_b;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
  endfunction

  task automatic evaluate_byte(input logic [CHAR_W-1:0] c, input logic is_last);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    expr_result_t      res;
    if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
      b = pop_operand();
      a = pop_operand();
      case (c)
        CH_ADD: r = a + b;
        CH_SUB: r = a - b;
        CH_MUL: r = a * b;
        default: r = quotient_toward_zero(a, b);
      endcase
      push_operand(r);
    end else begin
      push_operand({{(DATA_W-CHAR_W){1'b0}}, c} - ASCII_ZERO);
    end
    if (is_last) begin
      res.value = pop_operand();
      res.under = under_flag;
      res.over  = over_flag;
      res.div0  = div0_flag;
      expected_results.push_back(res);
      stack_fill = 0;
      under_flag = 1'b0;
      over_flag  = 1'b0;
      div0_flag  = 1'b0;
    end
  endtask

  task automatic check_result(input logic [DATA_W-1:0] value, input logic [FLAG_W-1:0] flags);
    expr_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%0d flags=%b", $signed(value), flags));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (want.under) underflow_seen++;
    if (want.over) overflow_seen++;
    if (want.div0) div0_seen++;
    if (value !== want.value)
      report_mismatch($sformatf("result_value got %0d want %0d",
                                $signed(value), $signed(want.value)));
    if (flags[0] !== want.under)
      report_mismatch($sformatf("underflow got %b want %b", flags[0], want.under));
    if (flags[1] !== want.over)
      report_mismatch($sformatf("overflow got %b want %b", flags[1], want.over));
    if (flags[2] !== want.div0)
      report_mismatch($sformatf("divide_by_zero got %b want %b", flags[2], want.div0));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stack_fill = 0;
      under_flag = 1'b0;
      over_flag  = 1'b0;
      div0_flag  = 1'b0;
      expected_results.delete();
    end else begin
      // output first: a result can never belong to a byte taken on the same edge
      if (m_tvalid && m_tready)
        check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready)
        evaluate_byte(s_tdata, s_tlast);
    end
    pending_results = expected_results.size();
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives expression bytes into the postfix evaluator in random bursts while
// the result side stalls on its own pattern. A short directed set covers the
// byte extremes, all four operators, underflow, divide by zero and min / -1.
// Random well-formed expressions, stack floods, broken expressions and noise
// follow. The checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import pfx_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 800_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [CHAR_W-1:0] OPERATORS [4] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [FLAG_W-1:0] m_tuser;

  int error_count;
  int pending_results;
  int results_checked;
  int underflow_seen;
  int overflow_seen;
  int div0_seen;

  int                items_sent = 0;
  int                burst_left = 0;
  int                cycle_count = 0;
  logic [CHAR_W-1:0] expr_bytes [$];

  always #5 clk = ~clk;

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  pfx_result_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .error_count    (error_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .underflow_seen (underflow_seen),
    .overflow_seen  (overflow_seen),
    .div0_seen      (div0_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               pending_results);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one item per call; a new burst may start with an idle gap
  task automatic send_item(input logic [CHAR_W-1:0] b, input logic is_last);
    logic ready_seen;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_bytes[i])
      send_item(expr_bytes[i], i == expr_bytes.size() - 1);
    expr_bytes.delete();
  endtask

  function automatic logic [CHAR_W-1:0] pick_operand();
    logic [CHAR_W-1:0] v;
    if ($urandom_range(0, 9) < 6)
      return 8'h30 + 8'($urandom_range(0, 9));
    do
      v = 8'($urandom_range(0, 255));
    while (v == CH_ADD || v == CH_SUB || v == CH_MUL || v == CH_DIV);
    return v;
  endfunction

  // valid RPN; with operands_first all operands are pushed before any operator
  task automatic build_wellformed(input int n_operands, input bit operands_first);
    int depth;
    int left;
    depth = 0;
    left  = n_operands;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || (!operands_first && $urandom_range(0, 2) == 0))) begin
        expr_bytes.push_back(OPERATORS[$urandom_range(0, 3)]);
        depth--;
      end else begin
        expr_bytes.push_back(pick_operand());
        depth++;
        left--;
      end
    end
  endtask

  initial begin
    int kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte extremes: (0 - 48) - (255 - 48)
    expr_bytes = '{8'h00, 8'hFF, CH_SUB};
    send_expression();
    // lone operator: both pops find the stack empty
    expr_bytes = '{CH_ADD};
    send_expression();
    // divide by zero
    expr_bytes = '{8'h35, 8'h30, CH_DIV};
    send_expression();
    // 32^6 * 2 wraps to the most negative value, then divide by (0 - 1)
    expr_bytes = '{8'h50, 8'h50, CH_MUL};
    repeat (4) begin
      expr_bytes.push_back(8'h50);
      expr_bytes.push_back(CH_MUL);
    end
    expr_bytes.push_back(8'h32);
    expr_bytes.push_back(CH_MUL);
    expr_bytes.push_back(8'h30);
    expr_bytes.push_back(8'h31);
    expr_bytes.push_back(CH_SUB);
    expr_bytes.push_back(CH_DIV);
    send_expression();

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_wellformed($urandom_range(1, ($urandom_range(0, 4) == 0) ? 24 : 6), 1'b0);
        send_expression();
      end else if (kind < 73) begin
        // flood the stack to hit overflow
        build_wellformed($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8), 1'b1);
        send_expression();
      end else if (kind < 86) begin
        // stray operator or operand: underflow or leftover entries
        build_wellformed($urandom_range(1, 6), 1'b0);
        expr_bytes.insert($urandom_range(0, expr_bytes.size()),
                          $urandom_range(0, 1) ? OPERATORS[$urandom_range(0, 3)]
                                               : pick_operand());
        send_expression();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
    build_wellformed(3, 1'b0);
    send_expression();
    s_tvalid <= 1'b0;

    do @(negedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input items and %0d compared expression results.",
             items_sent, results_checked);
    $display("Results flagged: underflow %0d, overflow %0d, divide by zero %0d.",
             underflow_seen, overflow_seen, div0_seen);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result side: random stall phases, one long hold-off to back up the block
  initial begin
    int phase;
    int span;
    int duty;
    phase = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (phase == 2) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      duty = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(15, 95);
      span = $urandom_range(40, 300);
      repeat (span) begin
        m_tready <= ($urandom_range(1, 100) <= duty);
        @(posedge clk);
      end
      phase++;
    end
  end

endmodule

@@ sim.f @@
rtl/pfx_pkg.sv
rtl/pfx_div.sv
rtl/pfx_dpath.sv
rtl/pfx_ctrl.sv
rtl/postfix_expression_evaluator_unit.sv
test/pfx_result_checker.sv
test/tb_top.sv
